>>> hw/rtl/rrq_pkg.sv
// Package for the three-class batched round-robin ticket queue.
// Holds payload structs, status and op codes, and default constants.
// Depends on nothing; every other file but rrq_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package rrq_pkg;

    localparam int NUM_CLASSES     = 3;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 16;
    localparam int FIELD_TAG_BITS  = 16;

    localparam logic [3:0] DEFAULT_QUANTUM = 4'd4;
    localparam logic [1:0] CLASS_INVALID   = 2'd3;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVE   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_CLASS = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic                      op;
        logic [1:0]                in_class;
        logic [FIELD_TAG_BITS-1:0] in_tag;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [FIELD_TAG_BITS-1:0] out_tag;
        logic [1:0]                out_class;
    } rsp_t;

    // Per-item decision handed from the controller to the result pipeline
    typedef struct packed {
        status_t    status;
        logic [1:0] out_class;
        logic       serve_ok;
    } decision_t;

endpackage

`default_nettype wire

>>> hw/rtl/rrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module rrq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // Hold read data between reads
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rrq_ctrl.sv
// Ring pointers, occupancy, turn state and quantum register of the queue.
// Decides each beat in one pass and drives the ticket RAM; uses rrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrq_ctrl #(
    parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = rrq_pkg::TAG_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [3:0]                             cfg_data,
    input  wire logic                                   fire,
    input  wire rrq_pkg::req_t                          req,
    output rrq_pkg::decision_t                          dec,
    output logic                                        mem_we,
    output logic [$clog2(3*QUEUE_DEPTH)-1:0]            mem_waddr,
    output logic [TAG_BITS-1:0]                         mem_wdata,
    output logic                                        mem_re,
    output logic [$clog2(3*QUEUE_DEPTH)-1:0]            mem_raddr
);

    import rrq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(3 * QUEUE_DEPTH);

    logic [IW-1:0] head_reg [NUM_CLASSES];
    logic [IW-1:0] tail_reg [NUM_CLASSES];
    logic [OW-1:0] occ_reg  [NUM_CLASSES];
    logic [IW-1:0] head_next [NUM_CLASSES];
    logic [IW-1:0] tail_next [NUM_CLASSES];
    logic [OW-1:0] occ_next  [NUM_CLASSES];
    logic [1:0]    cur_reg, cur_next;
    logic [3:0]    served_reg, served_next;
    logic [3:0]    quantum_reg;

    logic [NUM_CLASSES-1:0] nonempty;
    logic [NUM_CLASSES-1:0] full;
    logic [3:0]             q_eff;
    logic                   cls_ok;
    logic [1:0]             cls_idx;
    logic [1:0]             c1, c2, sel;
    logic [3:0]             served_sel;
    logic                   enq_ok, srv_ok;
    logic [63:0]            tag_wide;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
        return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [1:0] next_class(input logic [1:0] c);
        return (c == 2'(NUM_CLASSES - 1)) ? 2'd0 : c + 2'd1;
    endfunction

    always_comb
    begin
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            nonempty[k] = (occ_reg[k] != '0);
            full[k]     = (occ_reg[k] == OW'(QUEUE_DEPTH));
        end
    end

    assign q_eff   = (quantum_reg == 4'd0) ? 4'd1 : quantum_reg;
    assign cls_ok  = (req.in_class != CLASS_INVALID);
    assign cls_idx = cls_ok ? req.in_class : 2'd0;
    assign c1      = next_class(cur_reg);
    assign c2      = next_class(c1);

    // Stay while the turn has budget, else pass on; fall back to the current
    // class with a fresh turn when the other rings are empty.
    always_comb
    begin
        if (nonempty[cur_reg] && (served_reg < q_eff))
        begin
            sel        = cur_reg;
            served_sel = served_reg + 4'd1;
        end
        else if (nonempty[c1])
        begin
            sel        = c1;
            served_sel = 4'd1;
        end
        else if (nonempty[c2])
        begin
            sel        = c2;
            served_sel = 4'd1;
        end
        else
        begin
            sel        = cur_reg;
            served_sel = 4'd1;
        end
    end

    always_comb
    begin
        dec.out_class = 2'd0;
        dec.serve_ok  = 1'b0;
        enq_ok        = 1'b0;
        srv_ok        = 1'b0;
        if (req.op == OP_ENQUEUE)
        begin
            if (!cls_ok)
            begin
                dec.status = ST_BAD_CLASS;
            end
            else if (full[cls_idx])
            begin
                dec.status = ST_FULL;
            end
            else
            begin
                dec.status = ST_OK;
                enq_ok     = 1'b1;
            end
        end
        else
        begin
            if (nonempty == '0)
            begin
                dec.status = ST_EMPTY;
            end
            else
            begin
                dec.status    = ST_OK;
                dec.out_class = sel;
                dec.serve_ok  = 1'b1;
                srv_ok        = 1'b1;
            end
        end
    end

    assign tag_wide  = 64'(req.in_tag);
    assign mem_we    = fire && enq_ok;
    assign mem_re    = fire && srv_ok;
    assign mem_wdata = tag_wide[TAG_BITS-1:0];
    assign mem_waddr = AW'(cls_idx) * AW'(QUEUE_DEPTH) + AW'(tail_reg[cls_idx]);
    assign mem_raddr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(head_reg[sel]);

    always_comb
    begin
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            head_next[k] = head_reg[k];
            tail_next[k] = tail_reg[k];
            occ_next[k]  = occ_reg[k];
        end
        cur_next    = cur_reg;
        served_next = served_reg;
        if (mem_we)
        begin
            tail_next[cls_idx] = next_slot(tail_reg[cls_idx]);
            occ_next[cls_idx]  = occ_reg[cls_idx] + 1'b1;
        end
        if (mem_re)
        begin
            head_next[sel] = next_slot(head_reg[sel]);
            occ_next[sel]  = occ_reg[sel] - 1'b1;
            cur_next       = sel;
            served_next    = served_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
                occ_reg[k]  <= '0;
            end
            cur_reg     <= 2'd0;
            served_reg  <= 4'd0;
            quantum_reg <= DEFAULT_QUANTUM;
        end
        else
        begin
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                head_reg[k] <= head_next[k];
                tail_reg[k] <= tail_next[k];
                occ_reg[k]  <= occ_next[k];
            end
            cur_reg    <= cur_next;
            served_reg <= served_next;
            if (cfg_we)
            begin
                quantum_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/three_class_batched_round_robin_queue.sv
// Three-class batched round-robin ticket queue: one request beat per cycle
// enqueues a tag or serves the next ticket. Each beat is decided in the cycle
// it is accepted, and the ticket RAM that holds all three rings
// (3 * QUEUE_DEPTH entries) is read at the accepting edge. The decision is
// registered in stage 1, then moves with the read tag into the output
// register that offers the result. Sustained rate is one beat per cycle
// while rsp_ready stays high; a stalled output holds the pipeline and drops
// req_ready. No clearing pass after reset. Uses rrq_pkg, rrq_ctrl, rrq_ram.
`timescale 1ns / 1ps
`default_nettype none

module three_class_batched_round_robin_queue #(
    parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = rrq_pkg::TAG_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [3:0]    cfg_data,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire rrq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output rrq_pkg::rsp_t      rsp
);

    import rrq_pkg::*;

    localparam int AW = $clog2(3 * QUEUE_DEPTH);

    logic               fire;
    decision_t          dec;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [TAG_BITS-1:0] mem_wdata, mem_rdata;
    logic [63:0]        rdata_wide;

    logic      s1_valid_reg, s1_valid_next;
    decision_t s1_reg;
    logic      out_valid_reg, out_valid_next;
    rsp_t      out_reg;
    logic      s1_adv;

    assign req_ready = !s1_valid_reg || !out_valid_reg || rsp_ready;
    assign fire      = req_valid && req_ready;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp_ready);

    rrq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .req       (req),
        .dec       (dec),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr)
    );

    rrq_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (3 * QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rdata_wide = 64'(mem_rdata);

    always_comb
    begin
        if (fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: stage 1 waits for the RAM read, then moves to the output beat
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_reg <= dec;
        end
        if (s1_adv)
        begin
            out_reg.status    <= s1_reg.status;
            out_reg.out_class <= s1_reg.out_class;
            out_reg.out_tag   <= s1_reg.serve_ok ? rdata_wide[FIELD_TAG_BITS-1:0]
                                                 : '0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rrq_checker.sv
// Port-level checker for the round-robin ticket queue, bound to the top.
// Uses rrq_pkg for the payload types and status codes.
`timescale 1ns / 1ps
`default_nettype none

module rrq_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire rrq_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire rrq_pkg::rsp_t rsp
);

    import rrq_pkg::*;

    // A stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // A stalled request beat holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request beat changed while stalled");

    // Input side backs off only behind a waiting result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request ready low without output stall");

    // Dropped or empty results carry no ticket
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.out_tag == '0)
                                               && (rsp.out_class == 2'd0))
        else $error("failed result carries tag or class");

    // Served class is never the invalid code
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.out_class != CLASS_INVALID)
        else $error("result class out of range");

endmodule

bind three_class_batched_round_robin_queue rrq_checker u_rrq_checker (.*);

`default_nettype wire
